>>> rtl/jdj_pkg.sv
// jdj_pkg: shared types, constants and register codes of the joystick dead-zone jog unit.
// Used by jdj_cfg, jdj_ctrl, jdj_dpath and joystick_deadzone_jog_unit. No dependencies.
`timescale 1ns / 1ps
package jdj_pkg;

  // default values of the top-level parameters
  localparam int ADC_BITS_DEF         = 12;
  localparam int FILTER_FRAC_BITS_DEF = 16;

  // filter coefficient, 3277 / 2^16, about 0.05
  localparam int ALPHA_BITS  = 13;
  localparam logic [ALPHA_BITS-1:0] ALPHA_Q16 = 13'd3277;
  localparam int ALPHA_SHIFT = 16;

  // register widths
  localparam int CENTER_BITS = 12;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int BAND_BITS   = 15;
  localparam int JOG_BITS    = 2;
  localparam int DEFL_BITS   = 16;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // result stream
  localparam int OUT_TDATA_BITS = 40;

  // reset values
  localparam logic [CENTER_BITS-1:0] CENTER_RST = 12'd2048;
  localparam logic [GAIN_BITS-1:0]   GAIN_RST   = 16'd4096;
  localparam logic [BAND_BITS-1:0]   DEAD_RST   = 15'd20;
  localparam logic [BAND_BITS-1:0]   STEP_RST   = 15'd100;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_GAIN_X_POS     = 3'd2,
    REG_GAIN_X_NEG     = 3'd3,
    REG_GAIN_Y_POS     = 3'd4,
    REG_GAIN_Y_NEG     = 3'd5,
    REG_DEAD_BAND      = 3'd6,
    REG_STEP_THRESHOLD = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CENTER_BITS-1:0] center_x;
    logic [CENTER_BITS-1:0] center_y;
    logic [GAIN_BITS-1:0]   gain_x_pos;
    logic [GAIN_BITS-1:0]   gain_x_neg;
    logic [GAIN_BITS-1:0]   gain_y_pos;
    logic [GAIN_BITS-1:0]   gain_y_neg;
    logic [BAND_BITS-1:0]   dead_band;
    logic [BAND_BITS-1:0]   step_threshold;
  } cfg_t;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_FILT_X,
    MUL_FILT_Y,
    MUL_DEFL_X,
    MUL_DEFL_Y
  } mul_op_e;

  typedef struct packed {
    logic    load_in;
    mul_op_e mul_op;
    logic    upd_x;
    logic    upd_y;
    logic    rnd_x;
    logic    rnd_y;
    logic    jog_en;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT_X,
    ST_FILT_Y,
    ST_DEFL_X,
    ST_DEFL_Y,
    ST_ROUND_Y,
    ST_JOG
  } state_t;

endpackage

>>> rtl/jdj_cfg.sv
// jdj_cfg: configuration register file, written through a plain write port.
// Depends on jdj_pkg.
`timescale 1ns / 1ps
module jdj_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [jdj_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [jdj_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output jdj_pkg::cfg_t                      cfg
);
  import jdj_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= CENTER_RST;
      cfg.center_y       <= CENTER_RST;
      cfg.gain_x_pos     <= GAIN_RST;
      cfg.gain_x_neg     <= GAIN_RST;
      cfg.gain_y_pos     <= GAIN_RST;
      cfg.gain_y_neg     <= GAIN_RST;
      cfg.dead_band      <= DEAD_RST;
      cfg.step_threshold <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CENTER_X:       cfg.center_x       <= cfg_data[CENTER_BITS-1:0];
        REG_CENTER_Y:       cfg.center_y       <= cfg_data[CENTER_BITS-1:0];
        REG_GAIN_X_POS:     cfg.gain_x_pos     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_X_NEG:     cfg.gain_x_neg     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_Y_POS:     cfg.gain_y_pos     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_Y_NEG:     cfg.gain_y_neg     <= cfg_data[GAIN_BITS-1:0];
        REG_DEAD_BAND:      cfg.dead_band      <= cfg_data[BAND_BITS-1:0];
        REG_STEP_THRESHOLD: cfg.step_threshold <= cfg_data[BAND_BITS-1:0];
      endcase
    end
  end

endmodule

>>> rtl/jdj_ctrl.sv
// jdj_ctrl: sequencer that steps one request through the shared multiplier schedule
// and owns the stream handshakes. Depends on jdj_pkg.
`timescale 1ns / 1ps
module jdj_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output jdj_pkg::dp_cmd_t  cmd
);
  import jdj_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_FILT_X;
      ST_FILT_X:  state_next = ST_FILT_Y;
      ST_FILT_Y:  state_next = ST_DEFL_X;
      ST_DEFL_X:  state_next = ST_DEFL_Y;
      ST_DEFL_Y:  state_next = ST_ROUND_Y;
      ST_ROUND_Y: state_next = ST_JOG;
      ST_JOG:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_FILT_X:  cmd.mul_op = MUL_FILT_X;
      ST_FILT_Y: begin
        cmd.upd_x  = 1'b1;
        cmd.mul_op = MUL_FILT_Y;
      end
      ST_DEFL_X: begin
        cmd.upd_y  = 1'b1;
        cmd.mul_op = MUL_DEFL_X;
      end
      ST_DEFL_Y: begin
        cmd.rnd_x  = 1'b1;
        cmd.mul_op = MUL_DEFL_Y;
      end
      ST_ROUND_Y: cmd.rnd_y  = 1'b1;
      ST_JOG:     cmd.jog_en = out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.jog_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/jdj_dpath.sv
// jdj_dpath: filter state, shared multiplier, rounding, dead band and jog hold,
// and the result register. Depends on jdj_pkg.
`timescale 1ns / 1ps
module jdj_dpath #(
  parameter int ADC_BITS         = jdj_pkg::ADC_BITS_DEF,
  parameter int FILTER_FRAC_BITS = jdj_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  jdj_pkg::dp_cmd_t                     cmd,
  input  jdj_pkg::cfg_t                        cfg,
  input  logic [ADC_BITS-1:0]                  sample_x,
  input  logic [ADC_BITS-1:0]                  sample_y,
  output logic signed [jdj_pkg::JOG_BITS-1:0]  jog_x,
  output logic signed [jdj_pkg::JOG_BITS-1:0]  jog_y,
  output logic signed [jdj_pkg::DEFL_BITS-1:0] deflect_x,
  output logic signed [jdj_pkg::DEFL_BITS-1:0] deflect_y
);
  import jdj_pkg::*;

  localparam int SW  = ADC_BITS + FILTER_FRAC_BITS;   // filter state
  localparam int DW  = SW + 1;                        // signed difference
  localparam int MB  = GAIN_BITS + 1;                 // signed second operand
  localparam int PW  = DW + MB;                       // product
  localparam int RSH = FILTER_FRAC_BITS + GAIN_FRAC;
  localparam int BW  = BAND_BITS + 2;

  localparam logic [SW-1:0] TOP = {{ADC_BITS{1'b1}}, {FILTER_FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (RSH - 1);
  localparam logic signed [PW-1:0] SAT_MAX  = PW'(32'sd32767);
  localparam logic signed [PW-1:0] SAT_MIN  = ~SAT_MAX;
  localparam logic signed [DEFL_BITS-1:0] DEFL_MAX = {1'b0, {(DEFL_BITS-1){1'b1}}};
  localparam logic signed [DEFL_BITS-1:0] DEFL_MIN = {1'b1, {(DEFL_BITS-1){1'b0}}};
  localparam logic signed [JOG_BITS-1:0] JOG_POS  = 2'sd1;
  localparam logic signed [JOG_BITS-1:0] JOG_NEG  = -2'sd1;
  localparam logic signed [JOG_BITS-1:0] JOG_NONE = 2'sd0;

  logic [ADC_BITS-1:0]          samp_x;
  logic [ADC_BITS-1:0]          samp_y;
  logic [SW-1:0]                smooth_x;
  logic [SW-1:0]                smooth_y;
  logic signed [PW-1:0]         prod;
  logic signed [DEFL_BITS-1:0]  defl_x;
  logic signed [DEFL_BITS-1:0]  defl_y;
  logic signed [JOG_BITS-1:0]   held_jog_x;
  logic signed [JOG_BITS-1:0]   held_jog_y;

  logic signed [DW-1:0]         tgt_x, tgt_y, cen_x, cen_y;
  logic signed [DW-1:0]         dev_x, dev_y;
  logic signed [DW-1:0]         mul_a;
  logic signed [MB-1:0]         mul_b;
  logic signed [PW-1:0]         prod_next;
  logic signed [PW-1:0]         step_full;
  logic signed [SW+1:0]         filt_sum;
  logic [SW-1:0]                filt_next;
  logic signed [PW-1:0]         rnd_full;
  logic signed [DEFL_BITS-1:0]  rnd_sat;
  logic signed [BW-1:0]         db, th, vx, vy;
  logic                         band_x, band_y;
  logic signed [DEFL_BITS-1:0]  outx, outy;
  logic signed [JOG_BITS-1:0]   jog_x_next, jog_y_next;

  // targets and centers, both in filter fixed point
  assign tgt_x = {1'b0, samp_x, {FILTER_FRAC_BITS{1'b0}}};
  assign tgt_y = {1'b0, samp_y, {FILTER_FRAC_BITS{1'b0}}};
  assign cen_x = {1'b0, ADC_BITS'(cfg.center_x), {FILTER_FRAC_BITS{1'b0}}};
  assign cen_y = {1'b0, ADC_BITS'(cfg.center_y), {FILTER_FRAC_BITS{1'b0}}};
  assign dev_x = signed'({1'b0, smooth_x}) - cen_x;
  assign dev_y = signed'({1'b0, smooth_y}) - cen_y;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_op)
      MUL_FILT_X: begin
        mul_a = tgt_x - signed'({1'b0, smooth_x});
        mul_b = signed'(MB'(ALPHA_Q16));
      end
      MUL_FILT_Y: begin
        mul_a = tgt_y - signed'({1'b0, smooth_y});
        mul_b = signed'(MB'(ALPHA_Q16));
      end
      MUL_DEFL_X: begin
        mul_a = dev_x;
        mul_b = signed'({1'b0, dev_x[DW-1] ? cfg.gain_x_neg : cfg.gain_x_pos});
      end
      MUL_DEFL_Y: begin
        mul_a = dev_y;
        mul_b = signed'({1'b0, dev_y[DW-1] ? cfg.gain_y_neg : cfg.gain_y_pos});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // filter update: add floor(diff * alpha / 2^16), clamp to the code range
  always_comb begin
    step_full = prod >>> ALPHA_SHIFT;
    filt_sum  = signed'({2'b00, cmd.upd_x ? smooth_x : smooth_y}) + step_full[SW+1:0];
    if (filt_sum < 0) begin
      filt_next = '0;
    end else if (filt_sum > signed'({2'b00, TOP})) begin
      filt_next = TOP;
    end else begin
      filt_next = filt_sum[SW-1:0];
    end
  end

  // round half up and saturate to the deflection width
  always_comb begin
    rnd_full = (prod + RND_HALF) >>> RSH;
    if (rnd_full > SAT_MAX) begin
      rnd_sat = DEFL_MAX;
    end else if (rnd_full < SAT_MIN) begin
      rnd_sat = DEFL_MIN;
    end else begin
      rnd_sat = rnd_full[DEFL_BITS-1:0];
    end
  end

  // dead band first, then threshold; axes are crossed and the sign inverted
  always_comb begin
    db     = signed'({2'b00, cfg.dead_band});
    th     = signed'({2'b00, cfg.step_threshold});
    vx     = BW'(defl_x);
    vy     = BW'(defl_y);
    band_x = (vx > -db) && (vx < db);
    band_y = (vy > -db) && (vy < db);
    outx   = band_x ? '0 : defl_x;
    outy   = band_y ? '0 : defl_y;
    jog_y_next = held_jog_y;
    jog_x_next = held_jog_x;
    if (!band_x) begin
      if (vx > th) begin
        jog_y_next = JOG_NEG;
      end else if (vx < -th) begin
        jog_y_next = JOG_POS;
      end
    end
    if (!band_y) begin
      if (vy > th) begin
        jog_x_next = JOG_NEG;
      end else if (vy < -th) begin
        jog_x_next = JOG_POS;
      end
    end
    if (outx == '0 && outy == '0) begin
      jog_x_next = JOG_NONE;
      jog_y_next = JOG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_x   <= '0;
      smooth_y   <= '0;
      held_jog_x <= JOG_NONE;
      held_jog_y <= JOG_NONE;
    end else begin
      if (cmd.upd_x) smooth_x <= filt_next;
      if (cmd.upd_y) smooth_y <= filt_next;
      if (cmd.jog_en) begin
        held_jog_x <= jog_x_next;
        held_jog_y <= jog_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (cmd.load_in) begin
      samp_x <= sample_x;
      samp_y <= sample_y;
    end
    if (cmd.rnd_x) defl_x <= rnd_sat;
    if (cmd.rnd_y) defl_y <= rnd_sat;
    if (cmd.jog_en) begin
      jog_x     <= jog_x_next;
      jog_y     <= jog_y_next;
      deflect_x <= outx;
      deflect_y <= outy;
    end
  end

endmodule

>>> rtl/joystick_deadzone_jog_unit.sv
// joystick_deadzone_jog_unit: a request passes filter x, filter y, deflect x, deflect y,
// round y and jog, sharing one multiplier in turn; only then is a new request taken.
// A finished result waits in the output register while the next request is taken.
// rst (synchronous, active high) zeroes both filters and held jog directions, empties
// the output register and loads the configuration registers with their defaults.
// Depends on jdj_pkg, jdj_cfg, jdj_ctrl and jdj_dpath.
`timescale 1ns / 1ps
module joystick_deadzone_jog_unit #(
  parameter int ADC_BITS         = jdj_pkg::ADC_BITS_DEF,
  parameter int FILTER_FRAC_BITS = jdj_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // sample request stream
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // sample_x, sample_y (ADC_BITS each), zero padded to bytes
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]          s_tdata,
  // result stream
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // jog_x[1:0], jog_y[3:2], deflect_x[19:4], deflect_y[35:20], zero padded
  output logic [jdj_pkg::OUT_TDATA_BITS-1:0]       m_tdata,
  // configuration write port
  input  logic                                     cfg_we,
  input  logic [jdj_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [jdj_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import jdj_pkg::*;

  localparam int PAY_BITS = 2 * JOG_BITS + 2 * DEFL_BITS;

  cfg_t                        cfg;
  dp_cmd_t                     cmd;
  logic signed [JOG_BITS-1:0]  jog_x, jog_y;
  logic signed [DEFL_BITS-1:0] deflect_x, deflect_y;

  // configuration registers; the user must write them only while no request is in flight, the block does not enforce it
  jdj_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: accept, filter x, filter y, deflect x, deflect y, round y, jog/output
  jdj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath with the shared multiplier and the result register
  jdj_dpath #(
    .ADC_BITS         (ADC_BITS),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .sample_x  (s_tdata[ADC_BITS-1:0]),
    .sample_y  (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .jog_x     (jog_x),
    .jog_y     (jog_y),
    .deflect_x (deflect_x),
    .deflect_y (deflect_y)
  );

  // pack the result, lowest field first
  assign m_tdata = {{(OUT_TDATA_BITS-PAY_BITS){1'b0}}, deflect_y, deflect_x, jog_y, jog_x};

endmodule

>>> sim/tb_joystick_deadzone_jog_unit.sv
// tb_joystick_deadzone_jog_unit: self-checking bench for the joystick dead-zone jog unit.
// Predicts every result in a small tracker class; depends on jdj_pkg and the rtl top level.
`timescale 1ns / 1ps
module tb_joystick_deadzone_jog_unit;
  import jdj_pkg::*;

  localparam int ADC_W        = ADC_BITS_DEF;
  localparam int FRAC_W       = FILTER_FRAC_BITS_DEF;
  localparam int S_TDATA_BITS = ((2*ADC_W+7)/8)*8;
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake or write
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 20;    // wait after the last result before the final check
  localparam int ADC_TOP      = (1 << ADC_W) - 1;

  typedef logic [CFG_DATA_BITS-1:0] reg_set_t [8];

  typedef struct {
    logic signed [JOG_BITS-1:0]  jog_x;
    logic signed [JOG_BITS-1:0]  jog_y;
    logic signed [DEFL_BITS-1:0] deflect_x;
    logic signed [DEFL_BITS-1:0] deflect_y;
  } jog_result_t;

  // how the result side throttles m_tready
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_BLOCKS
  } ready_mode_e;

  // tracks filter state, held jogs and registers; queues the expected results
  class jog_tracker;
    cfg_t        regs;
    longint      smooth_x;
    longint      smooth_y;
    int          held_x;
    int          held_y;
    longint      alpha;
    jog_result_t pending_results[$];
    int          errors;

    function new();
      regs = '{center_x: CENTER_RST, center_y: CENTER_RST,
               gain_x_pos: GAIN_RST, gain_x_neg: GAIN_RST,
               gain_y_pos: GAIN_RST, gain_y_neg: GAIN_RST,
               dead_band: DEAD_RST, step_threshold: STEP_RST};
      smooth_x = 0;
      smooth_y = 0;
      held_x   = 0;
      held_y   = 0;
      alpha    = longint'(ALPHA_Q16);
      errors   = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] error: %s", $time, msg);
      errors++;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_CENTER_X:       regs.center_x       = val[CENTER_BITS-1:0];
        REG_CENTER_Y:       regs.center_y       = val[CENTER_BITS-1:0];
        REG_GAIN_X_POS:     regs.gain_x_pos     = val[GAIN_BITS-1:0];
        REG_GAIN_X_NEG:     regs.gain_x_neg     = val[GAIN_BITS-1:0];
        REG_GAIN_Y_POS:     regs.gain_y_pos     = val[GAIN_BITS-1:0];
        REG_GAIN_Y_NEG:     regs.gain_y_neg     = val[GAIN_BITS-1:0];
        REG_DEAD_BAND:      regs.dead_band      = val[BAND_BITS-1:0];
        REG_STEP_THRESHOLD: regs.step_threshold = val[BAND_BITS-1:0];
        default: ;
      endcase
    endfunction

    // one step of the 12.16 low-pass, clamped to the adc range
    function longint lowpass_step(longint s, logic [ADC_W-1:0] sample);
      longint target;
      longint top;
      longint delta;
      target = longint'(sample);
      target = target << FRAC_W;
      top    = longint'(ADC_TOP);
      top    = top << FRAC_W;
      delta  = (target - s) * alpha;
      s      = s + (delta >>> ALPHA_SHIFT);
      if (s < 0) s = 0;
      if (s > top) s = top;
      return s;
    endfunction

    // centered, gain-scaled, rounded half up and saturated
    function longint scaled_deflection(longint s, logic [CENTER_BITS-1:0] center,
                                       logic [GAIN_BITS-1:0] gpos,
                                       logic [GAIN_BITS-1:0] gneg);
      longint c;
      longint d;
      longint g;
      longint r;
      c = longint'(center);
      d = s - (c << FRAC_W);
      if (d >= 0) g = longint'(gpos);
      else g = longint'(gneg);
      r = (d * g + (64'sd1 << (FRAC_W + GAIN_FRAC - 1))) >>> (FRAC_W + GAIN_FRAC);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    // dead band first, then threshold sets the inverted held direction
    function longint dead_band_jog(longint v, inout int jog);
      longint db;
      longint th;
      db = longint'(regs.dead_band);
      th = longint'(regs.step_threshold);
      if (v > -db && v < db) return 0;
      if (v > th) jog = -1;
      else if (v < -th) jog = 1;
      return v;
    endfunction

    function void take_sample(logic [S_TDATA_BITS-1:0] data);
      jog_result_t want;
      longint dx;
      longint dy;
      smooth_x = lowpass_step(smooth_x, data[ADC_W-1:0]);
      smooth_y = lowpass_step(smooth_y, data[2*ADC_W-1:ADC_W]);
      dx = scaled_deflection(smooth_x, regs.center_x, regs.gain_x_pos, regs.gain_x_neg);
      dy = scaled_deflection(smooth_y, regs.center_y, regs.gain_y_pos, regs.gain_y_neg);
      // axes are crossed: x deflection steers the y jog and vice versa
      dx = dead_band_jog(dx, held_y);
      dy = dead_band_jog(dy, held_x);
      if (dx == 0 && dy == 0) begin
        held_x = 0;
        held_y = 0;
      end
      want.jog_x     = 2'(held_x);
      want.jog_y     = 2'(held_y);
      want.deflect_x = 16'(dx);
      want.deflect_y = 16'(dy);
      pending_results.push_back(want);
    endfunction

    function void match_result(logic [OUT_TDATA_BITS-1:0] data);
      jog_result_t want;
      jog_result_t got;
      if (pending_results.size() == 0) begin
        report($sformatf("result 0x%0h with nothing expected", data));
        return;
      end
      want = pending_results.pop_front();
      got.jog_x     = data[1:0];
      got.jog_y     = data[3:2];
      got.deflect_x = data[19:4];
      got.deflect_y = data[35:20];
      if (got.jog_x !== want.jog_x)
        report($sformatf("jog_x got %0d expected %0d", got.jog_x, want.jog_x));
      if (got.jog_y !== want.jog_y)
        report($sformatf("jog_y got %0d expected %0d", got.jog_y, want.jog_y));
      if (got.deflect_x !== want.deflect_x)
        report($sformatf("deflect_x got %0d expected %0d", got.deflect_x, want.deflect_x));
      if (got.deflect_y !== want.deflect_y)
        report($sformatf("deflect_y got %0d expected %0d", got.deflect_y, want.deflect_y));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void final_check();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_we    = 1'b0;
  cfg_reg_e                  cfg_index = REG_CENTER_X;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  jog_tracker  tracker;
  int          burst_left   = 0;
  int          idle_cycles  = 0;
  logic [15:0] pattern_tick = '0;
  ready_mode_e ready_mode   = RDY_ALWAYS;
  int          hold_left    = 0;

  joystick_deadzone_jog_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // monitor: register writes, accepted requests and accepted results, in that order
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) tracker.take_sample(s_tdata);
      if (m_tvalid && m_tready) tracker.match_result(m_tdata);
    end
  end

  // result side: the throttle mode is redrawn at random whenever pattern_tick[6:0] is zero
  always @(posedge clk) begin
    pattern_tick <= pattern_tick + 16'd1;
    if (pattern_tick[6:0] == 7'd0) ready_mode <= ready_mode_e'($urandom_range(0, 2));
    case (ready_mode)
      RDY_ALWAYS: m_tready <= 1'b1;
      RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      default: begin
        // long alternating blocks of ready and stall
        if (hold_left == 0) begin
          m_tready  <= ~m_tready;
          hold_left <= $urandom_range(0, 24);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ADC_W-1:0] adc_clip(int v);
    if (v < 0) return '0;
    if (v > ADC_TOP) return ADC_W'(ADC_TOP);
    return ADC_W'(v);
  endfunction

  // one request; the sender idles between bursts of random length
  task automatic send_item(logic [ADC_W-1:0] x, logic [ADC_W-1:0] y);
    int gap;
    logic [S_TDATA_BITS-1:0] data;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    data = '0;
    data[ADC_W-1:0]       = x;
    data[2*ADC_W-1:ADC_W] = y;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // stick held near (cx, cy) with some jitter
  task automatic send_run(int cx, int cy, int len, int jitter);
    for (int i = 0; i < len; i++)
      send_item(adc_clip(cx + $urandom_range(0, 2*jitter) - jitter),
                adc_clip(cy + $urandom_range(0, 2*jitter) - jitter));
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  task automatic write_regs(reg_set_t vals);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CFG_DATA_BITS'($urandom_range(1000, 24000));
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_center();
    int roll;
    logic [CENTER_BITS-1:0] c;
    roll = $urandom_range(0, 3);
    if (roll == 0) c = CENTER_RST;
    else if (roll == 1) c = CENTER_BITS'($urandom_range(0, ADC_TOP));
    else c = CENTER_BITS'($urandom_range(1500, 2600));
    // stray upper bits must be dropped by the register
    return {4'($urandom_range(0, 15)), c};
  endfunction

  function automatic int pick_axis_target();
    int roll;
    roll = $urandom_range(0, 4);
    if (roll == 0) return 0;
    if (roll == 1) return ADC_TOP;
    if (roll == 2) return $urandom_range(1800, 2300);
    return $urandom_range(0, ADC_TOP);
  endfunction

  // new register set, then mostly held-stick runs broken up by noise
  task automatic random_phase(int n_items);
    reg_set_t vals;
    int sent;
    int len;
    int roll;
    vals[REG_CENTER_X]   = pick_center();
    vals[REG_CENTER_Y]   = pick_center();
    vals[REG_GAIN_X_POS] = pick_gain();
    vals[REG_GAIN_X_NEG] = pick_gain();
    vals[REG_GAIN_Y_POS] = pick_gain();
    vals[REG_GAIN_Y_NEG] = pick_gain();
    roll = $urandom_range(0, 19);
    if (roll == 0) vals[REG_DEAD_BAND] = '1;
    else if (roll < 3) vals[REG_DEAD_BAND] = {1'($urandom_range(0, 1)), 15'd0};
    else vals[REG_DEAD_BAND] = {1'($urandom_range(0, 1)), 15'($urandom_range(1, 400))};
    vals[REG_STEP_THRESHOLD] = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 3000))};
    settle();
    write_regs(vals);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 2) begin
        // noise: unrelated samples
        len = $urandom_range(1, 8);
        if (len > n_items - sent) len = n_items - sent;
        for (int i = 0; i < len; i++)
          send_item(ADC_W'($urandom_range(0, ADC_TOP)), ADC_W'($urandom_range(0, ADC_TOP)));
      end else begin
        len = $urandom_range(10, 70);
        if (len > n_items - sent) len = n_items - sent;
        send_run(pick_axis_target(), pick_axis_target(), len, $urandom_range(0, 40));
      end
      sent += len;
    end
  endtask

  initial begin
    reg_set_t vals;
    int done_items;
    int n;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers, filters rising from zero; rail samples on both axes
    send_run(0, 0, 3, 0);
    send_run(ADC_TOP, ADC_TOP, 3, 0);
    send_run(ADC_TOP, 0, 2, 0);
    send_run(0, ADC_TOP, 2, 0);

    // every register at its top value, with bits beyond the register width set;
    // deflections saturate and still clear the widest band
    foreach (vals[i]) vals[i] = '1;
    settle();
    write_regs(vals);
    send_run(ADC_TOP, ADC_TOP, 2, 0);
    send_run(0, 0, 2, 0);

    // all zero: zero gain with a zero band gives exact zero deflection, which clears
    foreach (vals[i]) vals[i] = '0;
    settle();
    write_regs(vals);
    send_run(ADC_TOP, 0, 2, 0);
    send_run(0, ADC_TOP, 2, 0);

    // threshold inside the dead band: the band wins
    vals[REG_CENTER_X]       = CFG_DATA_BITS'(CENTER_RST);
    vals[REG_CENTER_Y]       = CFG_DATA_BITS'(CENTER_RST);
    vals[REG_GAIN_X_POS]     = GAIN_RST;
    vals[REG_GAIN_X_NEG]     = GAIN_RST;
    vals[REG_GAIN_Y_POS]     = GAIN_RST;
    vals[REG_GAIN_Y_NEG]     = GAIN_RST;
    vals[REG_DEAD_BAND]      = 16'd600;
    vals[REG_STEP_THRESHOLD] = 16'd50;
    settle();
    write_regs(vals);
    send_run(ADC_TOP, 0, 3, 0);
    send_run(int'(CENTER_RST), int'(CENTER_RST), 2, 0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      n = $urandom_range(60, 140);
      if (n > RANDOM_ITEMS - done_items) n = RANDOM_ITEMS - done_items;
      random_phase(n);
      done_items += n;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.final_check();
    if (tracker.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/jdj_pkg.sv
rtl/jdj_cfg.sv
rtl/jdj_ctrl.sv
rtl/jdj_dpath.sv
rtl/joystick_deadzone_jog_unit.sv
sim/tb_joystick_deadzone_jog_unit.sv
